/* hdl/awd_pkg.sv */
// Shared types and constants for the autocorrelation width detector.
`timescale 1ns / 1ps
package awd_pkg;
  localparam int MAX_LAGS   = 2048;
  localparam int MAX_PIXELS = 1048576;
  localparam int SUM_WIDTH  = 40;
  localparam int TOP_PEAKS  = 4;
  localparam int LAG_W      = $clog2(MAX_LAGS);
  localparam int CNT_W      = $clog2(MAX_PIXELS) + 1;
  localparam int PK_IDX_W   = $clog2(TOP_PEAKS);
  localparam int PK_CNT_W   = $clog2(TOP_PEAKS + 1);
  localparam int DOT_W      = 18;
  localparam int CFG_W      = 10;
  localparam int WID_W      = 12;

  typedef enum logic [0:0] {
    REG_ROW_MAX = 1'b0,
    REG_ROW_MIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_RD, ST_ACC_MUL, ST_ACC_WR, ST_PK_INIT, ST_PK_CHK,
    ST_PK_RDV, ST_PK_GETV, ST_PK_RDJ, ST_PK_CMP, ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic acc_issue;
    logic acc_mul;
    logic acc_write;
    logic count_inc;
    logic pk_init;
    logic v_issue;
    logic v_latch;
    logic j_issue;
    logic j_next;
    logic k_next;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic acc_en;
    logic last;
    logic k_end;
    logic few_lags;
    logic v_neg;
    logic k_last;
    logic j_bigger;
    logic j_at_hi;
    logic out_busy;
  } status_t;
endpackage

/* hdl/autocorrelation_width_detector_core.sv */
// Top level of the autocorrelation width detector.
`timescale 1ns / 1ps
// Pixels (red, green, blue, tlast) enter one item at a time. Each byte is
// centered by subtracting 128 and the block accumulates the saturating
// autocorrelation sum of every lag up to min(pixel index, 2047). The lag
// loop runs through one shared multiply-add unit over a 2048-entry pixel
// history RAM and a 2048-entry sum RAM, with read, multiply and write
// states per lag; no new pixel is accepted until the loop for the
// previous one is done. Pixels past 2^20 are not accumulated; only their
// tlast is looked at. On the item with tlast the block searches peaks over
// L = min(3*row_max+2, pixels, 2048) lags, reading the sum RAM one entry
// at a time. It then emits one item on m_* with the rounded mean gap of
// the strongest peaks and clears itself; sums need no clearing pass since
// a lag entry is only used once written for this data set. Registers
// (row_max at index 0, row_min at index 1) must be written through cfg_*
// only while idle; the block itself does not enforce this.
module autocorrelation_width_detector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // width[11:0], found[12], gaps_used[14:13], zero[15]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_data
);
  awd_pkg::cmd_t    cmd;
  awd_pkg::status_t status;
  logic [11:0] width;
  logic        found;
  logic [1:0]  gaps_used;

  // Controller: accept only when idle
  awd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid && s_tready),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  awd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_pix    (s_tdata),
    .in_last   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_width (width),
    .out_found (found),
    .out_gaps  (gaps_used)
  );

  assign m_tdata = {1'b0, gaps_used, found, width};
endmodule

/* hdl/awd_ctrl.sv */
// Sequencer for accumulation, peak search and result emission.
`timescale 1ns / 1ps
module awd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  awd_pkg::status_t  status,
  output logic              in_ready,
  output awd_pkg::cmd_t     cmd
);
  awd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= awd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      awd_pkg::ST_IDLE: begin
        if (in_fire) state_next = status.acc_en ? awd_pkg::ST_ACC_RD : awd_pkg::ST_PK_INIT;
      end
      awd_pkg::ST_ACC_RD:  state_next = awd_pkg::ST_ACC_MUL;
      awd_pkg::ST_ACC_MUL: state_next = awd_pkg::ST_ACC_WR;
      awd_pkg::ST_ACC_WR: begin
        if (!status.k_end) state_next = awd_pkg::ST_ACC_RD;
        else if (status.last) state_next = awd_pkg::ST_PK_INIT;
        else state_next = awd_pkg::ST_IDLE;
      end
      awd_pkg::ST_PK_INIT: state_next = awd_pkg::ST_PK_CHK;
      awd_pkg::ST_PK_CHK: begin
        // pixel past the accumulation limit without tlast: nothing to do
        if (!status.last) state_next = awd_pkg::ST_IDLE;
        else if (status.few_lags) state_next = awd_pkg::ST_WALK;
        else state_next = awd_pkg::ST_PK_RDV;
      end
      awd_pkg::ST_PK_RDV: state_next = awd_pkg::ST_PK_GETV;
      awd_pkg::ST_PK_GETV: begin
        if (!status.v_neg) state_next = awd_pkg::ST_PK_RDJ;
        else state_next = status.k_last ? awd_pkg::ST_WALK : awd_pkg::ST_PK_RDV;
      end
      awd_pkg::ST_PK_RDJ: state_next = awd_pkg::ST_PK_CMP;
      awd_pkg::ST_PK_CMP: begin
        if (status.j_bigger || status.j_at_hi)
          state_next = status.k_last ? awd_pkg::ST_WALK : awd_pkg::ST_PK_RDV;
        else
          state_next = awd_pkg::ST_PK_RDJ;
      end
      awd_pkg::ST_WALK: begin
        if (!status.out_busy) state_next = awd_pkg::ST_IDLE;
      end
      default: state_next = awd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      awd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      awd_pkg::ST_ACC_RD:  cmd.acc_issue = 1'b1;
      awd_pkg::ST_ACC_MUL: cmd.acc_mul = 1'b1;
      awd_pkg::ST_ACC_WR: begin
        cmd.acc_write = 1'b1;
        cmd.count_inc = status.k_end;
      end
      awd_pkg::ST_PK_INIT: cmd.pk_init = 1'b1;
      awd_pkg::ST_PK_CHK:  cmd.count_inc = 1'b0;
      awd_pkg::ST_PK_RDV:  cmd.v_issue = 1'b1;
      awd_pkg::ST_PK_GETV: begin
        cmd.v_latch = !status.v_neg;
        cmd.k_next  = status.v_neg;
      end
      awd_pkg::ST_PK_RDJ: cmd.j_issue = 1'b1;
      awd_pkg::ST_PK_CMP: begin
        cmd.insert = !status.j_bigger && status.j_at_hi;
        cmd.k_next = status.j_bigger || status.j_at_hi;
        cmd.j_next = !(status.j_bigger || status.j_at_hi);
      end
      awd_pkg::ST_WALK: cmd.emit = !status.out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

/* hdl/awd_datapath.sv */
// Lag-sum memories, peak list and width arithmetic.
`timescale 1ns / 1ps
module awd_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  awd_pkg::cmd_t              cmd,
  output awd_pkg::status_t           status,
  input  logic [23:0]                in_pix,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [awd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [awd_pkg::WID_W-1:0]  out_width,
  output logic                       out_found,
  output logic [1:0]                 out_gaps
);
  localparam int LW = awd_pkg::LAG_W;
  localparam int SW = awd_pkg::SUM_WIDTH;
  localparam int TP = awd_pkg::TOP_PEAKS;
  localparam int WID_W_L = awd_pkg::WID_W;

  logic [23:0] hist [awd_pkg::MAX_LAGS];
  logic [SW-1:0] sums [awd_pkg::MAX_LAGS];

  logic [awd_pkg::CFG_W-1:0] row_max, row_min;
  logic [23:0] pix, hist_q;
  logic last_flag;
  logic [awd_pkg::CNT_W-1:0] count;
  logic [LW-1:0] k, jj;
  logic [LW:0] len, hi;
  logic [LW-1:0] h;
  logic [SW-1:0] sum_q, v;
  logic [awd_pkg::DOT_W-1:0] prod;
  logic old_zero, old_zero_q;
  logic [LW-1:0] top_lag [TP];
  logic [SW-1:0] top_val [TP];
  logic [awd_pkg::PK_CNT_W-1:0] pc;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_max <= awd_pkg::CFG_W'(640);
      row_min <= awd_pkg::CFG_W'(16);
    end else if (cfg_we) begin
      case (cfg_addr)
        awd_pkg::REG_ROW_MAX: row_max <= cfg_data;
        awd_pkg::REG_ROW_MIN: row_min <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LW-1:0] n_lim;
  assign n_lim = (count >= awd_pkg::CNT_W'(awd_pkg::MAX_LAGS - 1)) ?
                 LW'(awd_pkg::MAX_LAGS - 1) : count[LW-1:0];

  // Centered dot product of history pixel and current pixel
  function automatic logic signed [awd_pkg::DOT_W-1:0] dot(input logic [23:0] a,
                                                          input logic [23:0] b);
    logic signed [awd_pkg::DOT_W-1:0] acc;
    logic signed [7:0] x, y;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      x = {~a[8*c+7], a[8*c +: 7]};
      y = {~b[8*c+7], b[8*c +: 7]};
      acc = acc + awd_pkg::DOT_W'(x * y);
    end
    return acc;
  endfunction

  logic signed [SW:0] sum_ext;
  logic [SW-1:0] sat;
  always_comb begin
    sum_ext = (old_zero_q ? '0 : {sum_q[SW-1], sum_q}) +
              {{(SW+1-awd_pkg::DOT_W){prod[awd_pkg::DOT_W-1]}}, prod};
    if (sum_ext[SW] != sum_ext[SW-1])
      sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    else
      sat = sum_ext[SW-1:0];
  end

  assign old_zero = (count == awd_pkg::CNT_W'(k));

  logic sum_rd;
  logic [LW-1:0] sum_raddr;
  always_comb begin
    sum_rd = cmd.acc_issue || cmd.v_issue || cmd.j_issue;
    sum_raddr = cmd.j_issue ? jj : k;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) hist[count[LW-1:0]] <= in_pix;
    if (cmd.acc_issue) hist_q <= hist[count[LW-1:0] - k];
    if (sum_rd) sum_q <= sums[sum_raddr];
    if (cmd.acc_write) sums[k] <= sat;
  end

  // Window bounds of the lag under test
  logic [LW:0] k_plus_h;
  assign k_plus_h = {1'b0, k} + {1'b0, h};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix <= in_pix;
      last_flag <= in_last;
    end
    if (cmd.acc_issue) old_zero_q <= old_zero;
    if (cmd.acc_mul) prod <= dot(hist_q, pix);
    if (cmd.v_latch) begin
      v  <= sum_q;
      jj <= (k > h) ? k - h : '0;
      hi <= (k_plus_h < len - 1'b1) ? k_plus_h : len - 1'b1;
    end else if (cmd.j_next) begin
      jj <= jj + 1'b1;
    end
  end

  logic [11:0] len_cfg;
  assign len_cfg = 12'(3 * row_max) + 12'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
      len   <= '0;
      h     <= '0;
    end else begin
      if (cmd.load || cmd.pk_init) k <= '0;
      else if (cmd.acc_write || cmd.k_next || cmd.insert) k <= k + 1'b1;
      if (cmd.count_inc) count <= count + 1'b1;
      else if (cmd.emit) count <= '0;
      if (cmd.pk_init) begin
        if (awd_pkg::CNT_W'(len_cfg) <= count && len_cfg <= 12'(awd_pkg::MAX_LAGS))
          len <= (LW+1)'(len_cfg);
        else if (count <= awd_pkg::CNT_W'(awd_pkg::MAX_LAGS))
          len <= count[LW:0];
        else
          len <= (LW+1)'(awd_pkg::MAX_LAGS);
        h <= (row_min == '0) ? '0 : LW'(row_min - 1'b1);
      end
    end
  end

  // Sorted insertion into the peak list
  logic [awd_pkg::PK_CNT_W-1:0] pos;
  always_comb begin
    pos = '0;
    for (int i = 0; i < TP; i++)
      if (awd_pkg::PK_CNT_W'(i) < pc && $signed(top_val[i]) >= $signed(v))
        pos = pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (cmd.emit) begin
      pc <= '0;
    end else if (cmd.insert && pos < awd_pkg::PK_CNT_W'(TP)) begin
      if (pc < awd_pkg::PK_CNT_W'(TP)) pc <= pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && pos < awd_pkg::PK_CNT_W'(TP)) begin
      for (int i = 0; i < TP; i++) begin
        if (awd_pkg::PK_CNT_W'(i) == pos) begin
          top_lag[i] <= k;
          top_val[i] <= v;
        end else if (awd_pkg::PK_CNT_W'(i) > pos && i > 0) begin
          top_lag[i] <= top_lag[i-1];
          top_val[i] <= top_val[i-1];
        end
      end
    end
  end

  // Walk the peak list, then rounded mean of the gaps
  logic [13:0] gap_sum, gs1;
  logic [1:0] gaps;
  logic [26:0] third;
  logic [WID_W_L-1:0] wid;
  always_comb begin
    logic [LW-1:0] prev;
    logic stop;
    prev = '0;
    stop = 1'b0;
    gap_sum = '0;
    gaps = '0;
    for (int i = 0; i < TP; i++) begin
      if (!stop && awd_pkg::PK_CNT_W'(i) < pc) begin
        if (i > 0) begin
          if (top_lag[i] < prev) stop = 1'b1;
          else begin
            gap_sum = gap_sum + 14'(top_lag[i] - prev);
            gaps = gaps + 1'b1;
          end
        end
        if (!stop) begin
          prev = top_lag[i];
          if (gaps == 2'd3) stop = 1'b1;
        end
      end
    end
    gs1   = gap_sum + 1'b1;
    third = 27'(gs1 * 14'd2731);
    case (gaps)
      2'd1:    wid = WID_W_L'(gap_sum);
      2'd2:    wid = WID_W_L'(gs1 >> 1);
      2'd3:    wid = WID_W_L'(third >> 13);
      default: wid = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.emit) begin
      out_width <= wid;
      out_found <= (gaps != 2'd0);
      out_gaps  <= gaps;
    end
  end

  always_comb begin
    status.acc_en   = count < awd_pkg::CNT_W'(awd_pkg::MAX_PIXELS);
    status.last     = last_flag;
    status.k_end    = (k == n_lim);
    status.few_lags = len < (LW+1)'(2);
    status.v_neg    = sum_q[SW-1];
    status.k_last   = ({1'b0, k} + (LW+1)'(2)) >= len;
    status.j_bigger = $signed(sum_q) > $signed(v);
    status.j_at_hi  = ({1'b0, jj} == hi);
    status.out_busy = out_valid && !out_ready;
  end

`ifndef NO_ASSERTIONS
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= awd_pkg::PK_CNT_W'(TP)) else $error("peak count overflow");
  a_insert_nonneg: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !v[SW-1]) else $error("negative peak inserted");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0 && pc == '0 && out_valid)) else $error("emit did not clear");
`endif
endmodule
